FILE: sv/soft_knee_compressor_curve_core_defines.svh
// assertion macros for the soft knee compressor curve core
`ifndef SOFT_KNEE_COMPRESSOR_CURVE_CORE_DEFINES_SVH
`define SOFT_KNEE_COMPRESSOR_CURVE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SKCC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SKCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/skcc_pkg.sv
// shared types and constants for the soft knee compressor curve core
`timescale 1ns / 1ps
package skcc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int LVL_W     = 16;
  localparam int RAT_W     = 13;
  localparam int KNEE_W    = 13;
  localparam int RW        = (RAT_W > FRAC_BITS) ? RAT_W : FRAC_BITS + 1;
  localparam int DIFF_W    = 16;
  localparam int SQ_W      = 2 * (KNEE_W + 1);
  localparam int PW        = SQ_W + RW;
  localparam int KR_W      = KNEE_W + RW;
  localparam int DW        = KR_W + 2;
  localparam int NUM_W     = PW + 2;
  localparam int DEN_W     = DW + 1;
  localparam int QW        = 16;
  localparam int REM_W     = DEN_W;
  localparam int EXT_W     = LVL_W + 2;

  localparam logic [RW-1:0] ONE_FX = RW'(1) << FRAC_BITS;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_KNEE,
    MODE_ABOVE
  } mode_e;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [LVL_W-1:0] x;
  } div_req_t;

  typedef struct packed {
    logic [QW-1:0]    quo;
    logic [LVL_W-1:0] x;
  } div_rsp_t;

endpackage

FILE: sv/skcc_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module skcc_div
  import skcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  div_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output div_rsp_t rsp_o
);

  logic             v_q   [QW];
  logic [REM_W-1:0] rem_q [QW];
  logic [QW-1:0]    low_q [QW];
  logic [DEN_W-1:0] den_q [QW];
  logic [LVL_W-1:0] x_q   [QW];
  logic [QW:0]      rdy;

  assign rdy[QW] = rsp_ready_i;
  assign req_ready_o = rdy[0];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [QW-1:0]    low_in;
    logic [DEN_W-1:0] den_in;
    logic [LVL_W-1:0] x_in;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W-1:0] rem_nx;

    if (j == 0) begin : g_first
      assign v_in   = req_valid_i;
      assign rem_in = REM_W'(req_i.num >> QW);
      assign low_in = req_i.num[QW-1:0];
      assign den_in = req_i.den;
      assign x_in   = req_i.x;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign den_in = den_q[j-1];
      assign x_in   = x_q[j-1];
    end

    assign trial  = {rem_in, low_in[QW-1]};
    assign ge     = trial >= {1'b0, den_in};
    assign rem_nx = ge ? REM_W'(trial - {1'b0, den_in}) : trial[REM_W-1:0];
    assign rdy[j] = !v_q[j] || rdy[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        rem_q[j] <= rem_nx;
        low_q[j] <= {low_in[QW-2:0], ge};
        den_q[j] <= den_in;
        x_q[j]   <= x_in;
      end
    end
  end

  assign rsp_valid_o = v_q[QW-1];
  assign rsp_o.quo   = low_q[QW-1];
  assign rsp_o.x     = x_q[QW-1];

endmodule

FILE: sv/soft_knee_compressor_curve_core.sv
// Soft-knee compressor gain curve in the dB domain (signed Q7.8 levels, Q5.8 ratio).
// Each input level beat yields one output level beat. Levels at or below threshold
// minus knee pass unchanged, levels inside the knee follow the quadratic blend and
// levels above it are scaled by the ratio; the result rounds to nearest (ties up)
// and saturates to 16 bits. One beat is accepted every cycle unless the output
// stalls; a beat passes 21 register stages: four front stages (compare, square,
// product, numerator setup), a 16-stage restoring divider that resolves one
// quotient bit per stage, and the saturating output register. The user must
// write registers through the cfg port only while no beat is in flight; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`include "soft_knee_compressor_curve_core_defines.svh"
module soft_knee_compressor_curve_core
  import skcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LVL_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LVL_W-1:0]     s_axis_tdata,  // [15:0] level_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [LVL_W-1:0]     m_axis_tdata   // [15:0] level_out
);

  localparam logic signed [EXT_W-1:0] LVL_MIN = -EXT_W'(32768);
  localparam logic signed [EXT_W-1:0] LVL_MAX = EXT_W'(32767);

  logic [LVL_W-1:0]  thr_q;
  logic [RAT_W-1:0]  ratio_q;
  logic [KNEE_W-1:0] knee_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      ratio_q <= RAT_W'(ONE_FX);
      knee_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q   <= cfg_wdata_i;
        CFG_RATIO:     ratio_q <= cfg_wdata_i[RAT_W-1:0];
        CFG_KNEE:      knee_q  <= cfg_wdata_i[KNEE_W-1:0];
        default:       ;
      endcase
    end
  end

  // stage enables, bubbles collapse
  logic en1, en2, en3, en4, en_out;
  logic div_req_ready, div_rsp_valid;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;

  assign en_out = !out_v_q || m_axis_tready;
  assign en4    = !s4_v_q || div_req_ready;
  assign en3    = !s3_v_q || en4;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    s1_v_q  <= s_axis_tvalid;
      if (en2)    s2_v_q  <= s1_v_q;
      if (en3)    s3_v_q  <= s2_v_q;
      if (en4)    s4_v_q  <= s3_v_q;
      if (en_out) out_v_q <= div_rsp_valid;
    end
  end

  // stage 1: region select and distance
  logic signed [EXT_W-1:0] x_ext, t_ext, k_ext, lo, hi, diff;
  logic [RW-1:0]           r_cl;
  mode_e                   mode_d;

  assign x_ext = {{2{s_axis_tdata[LVL_W-1]}}, s_axis_tdata};
  assign t_ext = {{2{thr_q[LVL_W-1]}}, thr_q};
  assign k_ext = {{(EXT_W-KNEE_W){1'b0}}, knee_q};
  assign lo    = t_ext - k_ext;
  assign hi    = t_ext + k_ext;
  assign r_cl  = (RW'(ratio_q) < ONE_FX) ? ONE_FX : RW'(ratio_q);

  always_comb begin
    priority if (x_ext <= lo) begin
      mode_d = MODE_PASS;
    end else if (x_ext < hi) begin
      mode_d = MODE_KNEE;
    end else begin
      mode_d = MODE_ABOVE;
    end
  end

  assign diff = x_ext - ((mode_d == MODE_KNEE) ? lo : t_ext);

  mode_e             s1_mode_q;
  logic [LVL_W-1:0]  s1_x_q;
  logic [DIFF_W-1:0] s1_a_q;
  logic [RW-1:0]     s1_r_q, s1_rm1_q;
  logic [KNEE_W-1:0] s1_k_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mode_q <= mode_d;
      s1_x_q    <= s_axis_tdata;
      s1_a_q    <= diff[DIFF_W-1:0];
      s1_r_q    <= r_cl;
      s1_rm1_q  <= r_cl - ONE_FX;
      s1_k_q    <= knee_q;
    end
  end

  // stage 2: square of knee distance, knee times ratio
  mode_e            s2_mode_q;
  logic [LVL_W-1:0] s2_x_q;
  logic [SQ_W-1:0]  s2_m_q;
  logic [KR_W-1:0]  s2_kr_q;
  logic [RW-1:0]    s2_r_q, s2_rm1_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_mode_q <= s1_mode_q;
      s2_x_q    <= s1_x_q;
      s2_m_q    <= (s1_mode_q == MODE_KNEE)
                   ? SQ_W'(s1_a_q[KNEE_W:0]) * SQ_W'(s1_a_q[KNEE_W:0])
                   : SQ_W'(s1_a_q);
      s2_kr_q   <= KR_W'(s1_k_q) * KR_W'(s1_r_q);
      s2_r_q    <= s1_r_q;
      s2_rm1_q  <= s1_rm1_q;
    end
  end

  // stage 3: numerator product and denominator
  mode_e            s3_mode_q;
  logic [LVL_W-1:0] s3_x_q;
  logic [PW-1:0]    s3_p_q;
  logic [DW-1:0]    s3_d_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_mode_q <= s2_mode_q;
      s3_x_q    <= s2_x_q;
      s3_p_q    <= (s2_mode_q == MODE_PASS) ? '0 : PW'(s2_m_q) * PW'(s2_rm1_q);
      s3_d_q    <= (s2_mode_q == MODE_KNEE) ? {s2_kr_q, 2'b00} : DW'(s2_r_q);
    end
  end

  // stage 4: rounding numerator, q = floor((2p + d - 1) / 2d), y = x - q
  div_req_t s4_req_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_req_q.num <= NUM_W'({s3_p_q, 1'b0}) + NUM_W'(s3_d_q) - NUM_W'(1);
      s4_req_q.den <= {s3_d_q, 1'b0};
      s4_req_q.x   <= s3_x_q;
    end
  end

  div_rsp_t div_rsp;

  skcc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s4_v_q),
    .req_ready_o (div_req_ready),
    .req_i       (s4_req_q),
    .rsp_valid_o (div_rsp_valid),
    .rsp_ready_i (en_out),
    .rsp_o       (div_rsp)
  );

  // output: subtract and saturate
  logic signed [EXT_W-1:0] y_raw;
  logic [LVL_W-1:0]        y_sat;
  logic [LVL_W-1:0]        out_q;

  assign y_raw = {{2{div_rsp.x[LVL_W-1]}}, div_rsp.x} - {{(EXT_W-QW){1'b0}}, div_rsp.quo};

  always_comb begin
    priority if (y_raw < LVL_MIN) begin
      y_sat = LVL_MIN[LVL_W-1:0];
    end else if (y_raw > LVL_MAX) begin
      y_sat = LVL_MAX[LVL_W-1:0];
    end else begin
      y_sat = y_raw[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q <= y_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `SKCC_ASSERT_IMPL(a_knee_needs_width, s1_v_q && s1_mode_q == MODE_KNEE, s1_k_q != '0, "knee beat with zero knee width")
  `SKCC_ASSERT_IMPL(a_empty_out_ready, !m_axis_tvalid, s_axis_tready, "input stalled while output empty")
  `SKCC_ASSERT_IMPL(a_div_den_nonzero, s4_v_q, s4_req_q.den != '0, "zero divisor entering divider")
  `SKCC_ASSERT_NEXT(a_s1_advances, s1_v_q && en2, s2_v_q, "beat lost between stage 1 and stage 2")

endmodule

FILE: dv/level_curve_checker.sv
// checker for the compressor curve core: tracks the registers, predicts each level and compares
`timescale 1ns / 1ps
module level_curve_checker
  import skcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LVL_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [LVL_W-1:0]     s_axis_tdata,  // [15:0] level_in
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [LVL_W-1:0]     m_axis_tdata,  // [15:0] level_out
  output int                   mismatch_count,
  output int                   levels_in_flight,
  output int                   levels_checked
);

  logic signed [LVL_W-1:0] thr_q;
  logic [RAT_W-1:0]        ratio_q;
  logic [KNEE_W-1:0]       knee_q;
  logic [LVL_W-1:0]        expected_levels[$];
  logic [LVL_W-1:0]        want_level;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [LVL_W-1:0] compress_level(logic [LVL_W-1:0] lvl);
    longint x, t, k, r, one, y, d, den, num;
    x   = longint'($signed(lvl));
    t   = longint'(thr_q);
    k   = longint'(knee_q);
    one = longint'(ONE_FX);
    r   = (longint'(ratio_q) < one) ? one : longint'(ratio_q);
    if (x <= t - k) begin
      y = x;
    end else if (x < t + k) begin
      d   = x - t + k;
      den = 4 * k * r;
      num = d * d * (r - one);
      y   = floor_quot(2 * (x * den - num) + den, 2 * den);
    end else begin
      num = x * r + (t - x) * (r - one);
      y   = floor_quot(2 * num + r, 2 * r);
    end
    if (y < -32768) y = -32768;
    if (y > 32767) y = 32767;
    return y[LVL_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      ratio_q <= RAT_W'(ONE_FX);
      knee_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q   <= cfg_wdata_i;
        CFG_RATIO:     ratio_q <= cfg_wdata_i[RAT_W-1:0];
        CFG_KNEE:      knee_q  <= cfg_wdata_i[KNEE_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_levels.push_back(compress_level(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        levels_checked++;
        if (expected_levels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output beat, expected none, actual %h", $time,
                   m_axis_tdata);
        end else begin
          want_level = expected_levels.pop_front();
          if (m_axis_tdata !== want_level) begin
            mismatch_count++;
            $display("%0t: level_out mismatch, expected %h, actual %h", $time,
                     want_level, m_axis_tdata);
          end
        end
      end
      levels_in_flight = expected_levels.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// top of the compressor curve testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import skcc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SINK_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 30;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_BEATS      = 206;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LVL_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [LVL_W-1:0]     s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [LVL_W-1:0]     m_axis_tdata;

  int mismatch_count;
  int levels_in_flight;
  int levels_checked;
  int settings_used;
  int cur_thr;
  int cur_knee;
  bit no_idle;
  bit hold_sink_req;

  soft_knee_compressor_curve_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  level_curve_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count   (mismatch_count),
    .levels_in_flight (levels_in_flight),
    .levels_checked   (levels_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: random stall per beat, plus one long hold-off on request
  initial begin
    int wait_cycles;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_sink_req) begin
        wait_cycles   = SINK_HOLD_CYCLES;
        hold_sink_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  function automatic logic [LVL_W-1:0] clamp_level(int v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[LVL_W-1:0];
  endfunction

  task automatic send_level(input logic [LVL_W-1:0] lvl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lvl;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // registers change only with the pipeline empty; unused bits and the spare index get noise
  task automatic set_curve(input int thr, input int rat, input int knee);
    s_axis_tvalid <= 1'b0;
    while (levels_in_flight != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_THRESHOLD;
    cfg_wdata_i <= thr[15:0];
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RATIO;
    cfg_wdata_i <= {3'($urandom), rat[12:0]};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_KNEE;
    cfg_wdata_i <= {3'($urandom), knee[12:0]};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    cur_thr  = int'($signed(thr[15:0]));
    cur_knee = knee & 8191;
    settings_used++;
  endtask

  initial begin
    int span;
    int ofs;
    int rat;
    int knee;
    logic [LVL_W-1:0] reset_levels[5];
    reset_levels  = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_THRESHOLD;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    hold_sink_req = 1'b0;
    settings_used = 1;
    cur_thr       = 0;
    cur_knee      = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset curve is the identity
    foreach (reset_levels[i]) send_level(reset_levels[i]);

    // soft knee: edges of all three regions
    set_curve(-5120, 1024, 1536);
    send_level(clamp_level(cur_thr - cur_knee));
    send_level(clamp_level(cur_thr - cur_knee + 1));
    send_level(clamp_level(cur_thr - 1));
    send_level(clamp_level(cur_thr));
    send_level(clamp_level(cur_thr + cur_knee - 1));
    send_level(clamp_level(cur_thr + cur_knee));
    send_level(16'h5555);
    send_level(16'haaaa);
    send_level(16'h7fff);

    // ratio below one acts as one
    set_curve(0, 0, 512);
    send_level(16'd100);
    send_level(16'd600);

    // hard corner at the threshold
    set_curve(256, 5120, 0);
    send_level(16'd255);
    send_level(16'd256);
    send_level(16'd257);
    send_level(16'h7fff);

    // knee reaching below the level range saturates low
    set_curve(-32768, 5120, 8191);
    send_level(16'h8000);
    send_level(clamp_level(-32000));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_curve(-32768, 5120, 8191);
        1: set_curve(32767, 256, 0);
        2: set_curve(-32768, 8191, 8191);
        default: begin
          case ($urandom_range(0, 4))
            0: rat = $urandom_range(0, 255);
            1: rat = $urandom_range(256, 5120);
            2: rat = $urandom_range(5121, 8191);
            3: rat = 256;
            default: rat = 5120;
          endcase
          case ($urandom_range(0, 3))
            0: knee = 0;
            1: knee = 8191;
            default: knee = $urandom_range(0, 8191);
          endcase
          set_curve(int'($signed(16'($urandom))), rat, knee);
        end
      endcase
      no_idle = (p % 3 == 2) || (p == 4);
      if (p == 4) hold_sink_req = 1'b1;
      repeat (PHASE_BEATS) begin
        if ($urandom_range(0, 9) < 6) begin
          span = cur_knee + 768;
          ofs  = int'($urandom_range(0, 2 * span)) - span;
          send_level(clamp_level(cur_thr + ofs));
        end else begin
          send_level(16'($urandom));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (levels_in_flight != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d output levels over %0d curve settings", levels_checked,
             settings_used);
    $display("incl. hard and soft knees, sub-unity ratios, low saturation, long output stall");
    if (mismatch_count == 0 && levels_in_flight == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
